// ===== rtl/a2d_pkg.sv =====
// Shared constants, angle table and stage control type for the atan2 degrees unit.
`default_nettype none
package a2d_pkg;

   localparam int ZFRAC   = 24;
   localparam int ZW      = 35;
   localparam int TAB_LEN = 24;
   localparam int OUT_W   = 17;

   localparam logic [29:0] ATAN_TAB [0:TAB_LEN-1] = '{
      30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
      30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
      30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
      30'd234684,    30'd117342,    30'd58671,     30'd29335,
      30'd14668,     30'd7334,      30'd3667,      30'd1833,
      30'd917,       30'd458,       30'd229,       30'd115
   };

   localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180) <<< ZFRAC;
   localparam logic signed [ZW-1:0] Z_FULL_TURN = ZW'(360) <<< ZFRAC;

   typedef struct packed {
      logic valid;
      logic zero;
   } a2d_ctl_type;

endpackage
`default_nettype wire

// ===== rtl/a2d_prerot.sv =====
// Input stage: sign extension, half-plane pre-rotation and scaling.
`default_nettype none
module a2d_prerot #(
   parameter int INPUT_WIDTH = 16,
   parameter int DW          = 43
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   input  wire signed [INPUT_WIDTH-1:0] req_x_in,
   input  wire signed [INPUT_WIDTH-1:0] req_y_in,
   output logic                         up_en,
   input  wire                          down_en,
   output a2d_pkg::a2d_ctl_type         ctl_out,
   output logic signed [DW-1:0]         x_out,
   output logic signed [DW-1:0]         y_out,
   output logic signed [a2d_pkg::ZW-1:0] z_out
);
   import a2d_pkg::*;

   a2d_ctl_type           ctl_ff, ctl_in;
   logic signed [DW-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic signed [DW-1:0]  xe, ye, xn, yn;
   logic                  neg;
   logic                  en;

   assign en    = !ctl_ff.valid || down_en;
   assign up_en = en;

   always_comb begin
      xe           = DW'(req_x_in);
      ye           = DW'(req_y_in);
      neg          = req_x_in[INPUT_WIDTH-1];
      xn           = neg ? -xe : xe;
      yn           = neg ? -ye : ye;
      x_in         = xn <<< ZFRAC;
      y_in         = yn <<< ZFRAC;
      z_in         = neg ? Z_HALF_TURN : '0;
      ctl_in.valid = req_valid;
      ctl_in.zero  = (req_x_in == '0) && (req_y_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign z_out   = z_ff;

   // A zero vector must leave this stage with all components cleared.
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff.valid && ctl_ff.zero) |-> (x_ff == '0 && y_ff == '0 && z_ff == '0))
      else $error("zero vector carries non-zero components");

endmodule
`default_nettype wire

// ===== rtl/a2d_micro.sv =====
// One CORDIC vectoring micro-rotation as a pipeline stage.
`default_nettype none
module a2d_micro #(
   parameter int DW    = 43,
   parameter int SHIFT = 0
) (
   input  wire                           clock,
   input  wire                           reset,
   input  a2d_pkg::a2d_ctl_type          ctl_up,
   input  wire signed [DW-1:0]           x_up,
   input  wire signed [DW-1:0]           y_up,
   input  wire signed [a2d_pkg::ZW-1:0]  z_up,
   output logic                          up_en,
   input  wire                           down_en,
   output a2d_pkg::a2d_ctl_type          ctl_out,
   output logic signed [DW-1:0]          x_out,
   output logic signed [DW-1:0]          y_out,
   output logic signed [a2d_pkg::ZW-1:0] z_out
);
   import a2d_pkg::*;

   localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_TAB[SHIFT]);

   a2d_ctl_type           ctl_ff;
   logic signed [DW-1:0]  x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic                  en;

   assign en    = !ctl_ff.valid || down_en;
   assign up_en = en;

   always_comb begin
      dx = y_up >>> SHIFT;
      dy = x_up >>> SHIFT;
      if (!y_up[DW-1]) begin
         x_in = x_up + dx;
         y_in = y_up - dy;
         z_in = z_up + ANGLE;
      end else begin
         x_in = x_up - dx;
         y_in = y_up + dy;
         z_in = z_up - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_up;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign x_out   = x_ff;
   assign y_out   = y_ff;
   assign z_out   = z_ff;

   // After pre-rotation the x component only grows, so it never turns negative.
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.valid |-> !x_ff[DW-1])
      else $error("x component went negative");

endmodule
`default_nettype wire

// ===== rtl/a2d_post.sv =====
// Output stages: fold into a full turn, round to the output fraction and wrap.
`default_nettype none
module a2d_post #(
   parameter int FRAC_BITS = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  a2d_pkg::a2d_ctl_type               ctl_up,
   input  wire signed [a2d_pkg::ZW-1:0]       z_up,
   output logic                               up_en,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [a2d_pkg::OUT_W-1:0]          rsp_angle_deg
);
   import a2d_pkg::*;

   localparam int UW = ZW - 1;
   localparam int SH = ZFRAC - FRAC_BITS;
   localparam int RW = UW - SH;
   localparam logic [UW-1:0] HALF     = UW'(1) << (SH - 1);
   localparam logic [UW-1:0] FULL_U   = UW'(Z_FULL_TURN);
   localparam logic [RW-1:0] FULL_OUT = RW'(360) << FRAC_BITS;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [UW-1:0]         z1_ff, z1_in, sum;
   logic [RW-1:0]         r2_ff, r2_in, r3_ff, r3_in;
   logic signed [ZW-1:0]  zf;
   logic                  en1, en2, en3;

   assign en3   = !v3_ff || !rsp_stall;
   assign en2   = !v2_ff || en3;
   assign en1   = !v1_ff || en2;
   assign up_en = en1;

   always_comb begin
      zf = z_up[ZW-1] ? z_up + Z_FULL_TURN : z_up;
      if (zf[ZW-1] || ctl_up.zero) begin
         z1_in = '0;
      end else begin
         z1_in = UW'(zf);
      end
      sum   = z1_ff + HALF;
      r2_in = RW'(sum >> SH);
      r3_in = (r2_ff >= FULL_OUT) ? r2_ff - FULL_OUT : r2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= ctl_up.valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         z1_ff <= z1_in;
      end
      if (en2) begin
         r2_ff <= r2_in;
      end
      if (en3) begin
         r3_ff <= r3_in;
      end
   end

   assign rsp_valid     = v3_ff;
   assign rsp_angle_deg = OUT_W'(r3_ff);

   a_fold_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (z1_ff < FULL_U))
      else $error("folded angle outside one turn");

   a_wrap_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (r3_ff < FULL_OUT))
      else $error("rounded angle not wrapped below a full turn");

endmodule
`default_nettype wire

// ===== rtl/atan2_degrees_unit.sv =====
// Top level of the pipelined CORDIC atan2 unit returning degrees in [0, 360).
// The number of micro-rotations is ITERATIONS, clamped to at most 24.
// Throughput: one transfer per cycle while the output is not stalled; one pre-rotation stage,
// one stage per micro-rotation and three output stages, each with its own valid bit.
// A stalled stage holds its contents while empty stages upstream keep filling.
// Synchronous reset clears every valid bit; the data registers are not reset.
`default_nettype none
module atan2_degrees_unit #(
   parameter int INPUT_WIDTH = 16,
   parameter int ITERATIONS  = 16,
   parameter int FRAC_BITS   = 8
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  wire signed [INPUT_WIDTH-1:0]   req_x_in,
   input  wire signed [INPUT_WIDTH-1:0]   req_y_in,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic [a2d_pkg::OUT_W-1:0]      rsp_angle_deg
);
   import a2d_pkg::*;

   localparam int NITER = (ITERATIONS > TAB_LEN) ? TAB_LEN : ITERATIONS;
   localparam int DW    = INPUT_WIDTH + 3 + ZFRAC;

   a2d_ctl_type           ctl_s [0:NITER];
   logic signed [DW-1:0]  x_s   [0:NITER];
   logic signed [DW-1:0]  y_s   [0:NITER];
   logic signed [ZW-1:0]  z_s   [0:NITER];
   logic                  rdy_s [0:NITER];
   logic                  pre_en;

   assign req_stall = !pre_en;

   a2d_prerot #(
      .INPUT_WIDTH(INPUT_WIDTH),
      .DW         (DW)
   ) u_prerot (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_x_in (req_x_in),
      .req_y_in (req_y_in),
      .up_en    (pre_en),
      .down_en  (rdy_s[0]),
      .ctl_out  (ctl_s[0]),
      .x_out    (x_s[0]),
      .y_out    (y_s[0]),
      .z_out    (z_s[0])
   );

   for (genvar i = 0; i < NITER; i++) begin : g_iter
      a2d_micro #(
         .DW   (DW),
         .SHIFT(i)
      ) u_micro (
         .clock  (clock),
         .reset  (reset),
         .ctl_up (ctl_s[i]),
         .x_up   (x_s[i]),
         .y_up   (y_s[i]),
         .z_up   (z_s[i]),
         .up_en  (rdy_s[i]),
         .down_en(rdy_s[i+1]),
         .ctl_out(ctl_s[i+1]),
         .x_out  (x_s[i+1]),
         .y_out  (y_s[i+1]),
         .z_out  (z_s[i+1])
      );
   end

   a2d_post #(
      .FRAC_BITS(FRAC_BITS)
   ) u_post (
      .clock        (clock),
      .reset        (reset),
      .ctl_up       (ctl_s[NITER]),
      .z_up         (z_s[NITER]),
      .up_en        (rdy_s[NITER]),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_angle_deg(rsp_angle_deg)
   );

endmodule
`default_nettype wire

// ===== tb/atan2_degrees_unit_test.sv =====
// Self-checking testbench for the atan2 degrees unit with randomised flow control on both sides.
`default_nettype none
module atan2_degrees_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VEC_W      = 16;
   localparam int STAGES     = 16;
   localparam int DEG_FRAC   = 8;
   localparam int ACC_FRAC   = 24;
   localparam int RANDOM_ITEMS = 1550;

   localparam longint DEG_STEP [0:STAGES-1] = '{
      754974720, 445687602, 235489088, 119537938,
      60000934,  30029717,  15018523,  7509720,
      3754917,   1877466,   938734,    469367,
      234684,    117342,    58671,     29335
   };

   typedef struct {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [VEC_W-1:0] req_x_in = '0;
   logic signed [VEC_W-1:0] req_y_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [a2d_pkg::OUT_W-1:0] rsp_angle_deg;

   vector_type pending_vectors[$];
   logic [a2d_pkg::OUT_W-1:0] expected_angles[$];
   logic vec_taken = 1'b0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   bit send_calm = 1'b0;
   bit stall_calm = 1'b0;
   int mismatches = 0;

   atan2_degrees_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_x_in(req_x_in),
      .req_y_in(req_y_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_angle_deg(rsp_angle_deg)
   );

   function automatic logic [a2d_pkg::OUT_W-1:0] vector_angle(logic signed [VEC_W-1:0] xi,
                                                              logic signed [VEC_W-1:0] yi);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint unsigned r;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0)
         return '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = longint'(180) <<< ACC_FRAC;
      end
      x = x <<< ACC_FRAC;
      y = y <<< ACC_FRAC;
      for (int i = 0; i < STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + DEG_STEP[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - DEG_STEP[i];
         end
      end
      if (z < 0)
         z = z + (longint'(360) <<< ACC_FRAC);
      if (z < 0)
         z = 0;
      r = (longint'(z) + (longint'(1) <<< (ACC_FRAC - DEG_FRAC - 1))) >> (ACC_FRAC - DEG_FRAC);
      if (r >= (longint'(360) <<< DEG_FRAC))
         r = r - (longint'(360) <<< DEG_FRAC);
      return r[a2d_pkg::OUT_W-1:0];
   endfunction

   function automatic int unsigned idle_length(bit calm);
      int unsigned pick;
      if (calm)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      else if (pick < 90)
         return $urandom_range(1, 3);
      else if (pick < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [VEC_W-1:0] corner_value();
      case ($urandom_range(0, 6))
         0: return 16'sh8000;
         1: return -16'sd32767;
         2: return -16'sd1;
         3: return 16'sd0;
         4: return 16'sd1;
         5: return 16'sd32766;
         default: return 16'sd32767;
      endcase
   endfunction

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2000000;
      $display("[atan2_degrees_unit] ERROR");
      $finish;
   end

   always @(negedge clock) begin : send_side
      vector_type next_vec;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || vec_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_vectors.size() > 0) begin
            next_vec = pending_vectors.pop_front();
            req_x_in <= next_vec.x;
            req_y_in <= next_vec.y;
            req_valid <= 1'b1;
            send_gap <= idle_length(send_calm);
            if ($urandom_range(0, 149) == 0)
               send_calm <= !send_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= idle_length(stall_calm);
         if ($urandom_range(0, 149) == 0)
            stall_calm <= !stall_calm;
      end
   end

   always @(posedge clock) begin : watch_side
      logic [a2d_pkg::OUT_W-1:0] want;
      if (reset) begin
         vec_taken <= 1'b0;
      end else begin
         vec_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("angle_deg transfer with no result pending: actual %0d", rsp_angle_deg);
               mismatches++;
            end else begin
               want = expected_angles.pop_front();
               if (rsp_angle_deg !== want) begin
                  $error("angle_deg mismatch: expected %0d, actual %0d", want, rsp_angle_deg);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_angles.push_back(vector_angle(req_x_in, req_y_in));
      end
   end

   initial begin : stimulus
      vector_type v;
      int waited;
      int fixed_x [0:21] = '{
         0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, 1, -1,
         0, 0, 1, -1, -1, 1, 32767, -32768, -32768, 32767, -1
      };
      int fixed_y [0:21] = '{
         0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 0, 0,
         1, -1, -1, 1, -1, 1, -1, -1, 1, 1, -32768
      };
      for (int i = 0; i < 22; i++) begin
         v.x = VEC_W'(fixed_x[i]);
         v.y = VEC_W'(fixed_y[i]);
         pending_vectors.push_back(v);
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 5))
            0, 1: begin
               v.x = VEC_W'($urandom());
               v.y = VEC_W'($urandom());
            end
            2: begin
               v.x = VEC_W'($urandom_range(0, 16) - 8);
               v.y = VEC_W'($urandom_range(0, 16) - 8);
            end
            3: begin
               if ($urandom_range(0, 1)) begin
                  v.x = VEC_W'($urandom_range(0, 2) - 1);
                  v.y = VEC_W'($urandom());
               end else begin
                  v.x = VEC_W'($urandom());
                  v.y = VEC_W'($urandom_range(0, 2) - 1);
               end
            end
            4: begin
               v.x = VEC_W'($urandom());
               v.y = VEC_W'(($urandom_range(0, 1) ? v.x : -v.x) + ($urandom_range(0, 6) - 3));
            end
            default: begin
               v.x = corner_value();
               v.y = corner_value();
            end
         endcase
         pending_vectors.push_back(v);
      end
      @(negedge reset);
      while (pending_vectors.size() != 0 || req_valid)
         @(posedge clock);
      waited = 0;
      while (expected_angles.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (expected_angles.size() != 0) begin
         $error("angle_deg results still pending at the end: %0d", expected_angles.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("[atan2_degrees_unit] OK");
      else
         $display("[atan2_degrees_unit] ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ===== atan2_degrees_unit.f =====
rtl/a2d_pkg.sv
rtl/a2d_prerot.sv
rtl/a2d_micro.sv
rtl/a2d_post.sv
rtl/atan2_degrees_unit.sv
tb/atan2_degrees_unit_test.sv
